### hw/rtl/shx_pkg.sv
// Shared types, constants and the hash fold function for the shift-xor string hash.
// No dependencies; every other file imports this package.
`default_nettype none

package shx_pkg;

  localparam int HASH_W          = 32;
  localparam int KEY_LEN_W       = 16;
  localparam int BYTE_W          = 8;
  localparam int MOD_W           = 16;
  localparam int ROT             = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(251);

  // Write side of the hash queue
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } q_wr_t;

  // Queue status seen by both front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  // (h << 4) ^ (h >> 28) is a rotate left by 4; xor in the byte
  function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    return {h[HASH_W-ROT-1:0], h[HASH_W-1:HASH_W-ROT]} ^ {{(HASH_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/shx_if.sv
// Channel interfaces: key byte input, bucket output and modulus configuration.
// Depends on shx_pkg.
`default_nettype none

interface shx_in_if;
  import shx_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KEY_LEN_W-1:0] key_length;
  logic [BYTE_W-1:0]    data_byte;
  logic                 last_byte;

  modport source (output valid, key_length, data_byte, last_byte, input ready);
  modport sink   (input valid, key_length, data_byte, last_byte, output ready);
endinterface

interface shx_out_if;
  import shx_pkg::*;
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] bucket_index;

  modport source (output valid, bucket_index, input ready);
  modport sink   (input valid, bucket_index, output ready);
endinterface

interface shx_cfg_if;
  import shx_pkg::*;
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/shx_front.sv
// Front end: accepts key bytes, folds them into the running hash, pushes finished hashes.
// Depends on shx_pkg and shx_if.
`default_nettype none

module shx_front (
  input  wire logic            clk,
  input  wire logic            rst,
  shx_in_if.sink               in_ch,
  input  wire shx_pkg::q_stat_t stat,
  output shx_pkg::q_wr_t       wr
);
  import shx_pkg::*;

  logic [HASH_W-1:0] running_hash;
  logic              key_start;
  logic              accept;
  logic              empty_key;
  logic [HASH_W-1:0] seed;
  logic [HASH_W-1:0] folded;

  // hold off input whenever the queue has no room
  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign empty_key   = key_start && (in_ch.key_length == '0);
  assign seed        = key_start ? {{(HASH_W-KEY_LEN_W){1'b0}}, in_ch.key_length}
                                 : running_hash;
  assign folded      = fold_byte(seed, in_ch.data_byte);

  always_comb begin
    wr.valid = accept && (empty_key || in_ch.last_byte);
    wr.hash  = empty_key ? '0 : folded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      key_start    <= 1'b1;
    end else if (accept) begin
      if (empty_key) begin
        running_hash <= '0;
        key_start    <= 1'b1;
      end else begin
        running_hash <= folded;
        key_start    <= in_ch.last_byte;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/shx_queue.sv
// Short queue of finished hashes between the front and the back.
// Depends on shx_pkg.
`default_nettype none

module shx_queue #(
  parameter int DEPTH = shx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire shx_pkg::q_wr_t            wr,
  input  wire logic                      pop,
  output logic [shx_pkg::HASH_W-1:0]     rd_data,
  output shx_pkg::q_stat_t               stat
);
  import shx_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [HASH_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign do_push    = wr.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/shx_back.sv
// Back end: bit-serial remainder of a queued hash by the modulus, held in the output register.
// Depends on shx_pkg and shx_if.
`default_nettype none

module shx_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [shx_pkg::MOD_W-1:0]  modulus,
  input  wire logic [shx_pkg::HASH_W-1:0] rd_data,
  input  wire shx_pkg::q_stat_t       stat,
  output logic                        pop,
  shx_out_if.source                   out_ch
);
  import shx_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);

  back_state_t       state;
  back_state_t       state_next;
  logic [HASH_W-1:0] dividend;
  logic [MOD_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [MOD_W:0]    trial;
  logic              fits;

  // one quotient bit per cycle: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, dividend[HASH_W-1]};
  assign fits  = (trial >= {1'b0, modulus});

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!stat.empty) begin
          state_next = (modulus == '0) ? BK_HOLD : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt == CNT_W'(HASH_W - 1)) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_ch.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop              = 1'b0;
    out_ch.valid     = 1'b0;
    out_ch.bucket_index = rem;
    unique case (state)
      BK_IDLE: pop          = !stat.empty;
      BK_DIV:  pop          = 1'b0;
      BK_HOLD: out_ch.valid = 1'b1;
      default: pop          = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        dividend <= rd_data;
        cnt      <= '0;
        // a zero modulus means 65536: the low half is the answer
        rem      <= (modulus == '0) ? rd_data[MOD_W-1:0] : '0;
      end
      BK_DIV: begin
        dividend <= {dividend[HASH_W-2:0], 1'b0};
        cnt      <= cnt + 1'b1;
        rem      <= fits ? MOD_W'(trial - {1'b0, modulus}) : trial[MOD_W-1:0];
      end
      BK_HOLD: begin
        rem <= rem;
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/shift_xor_string_hash_mod.sv
// Top level of the shift-xor string hash: front, hash queue, back and modulus register.
// Depends on shx_pkg, shx_if, shx_front, shx_queue and shx_back.
//
// Usage:
//   in_ch  - one key byte per transaction with key_length (sampled on the first
//            byte of a key) and last_byte marking the final byte. A first item
//            with key_length zero is a whole key by itself and yields 0.
//   out_ch - one bucket_index transaction per key: hash modulo bucket_modulus.
//   cfg    - writes bucket_modulus (reset 251); zero acts as 65536. Write only
//            while the block is idle. cfg.ready is always high.
// Timing:
//   The front folds one byte per cycle, so keys stream at one byte a cycle as
//   long as the hash queue has room. The back reduces one hash at a time with
//   a bit-serial remainder unit: while idle it pops a queued hash, then shifts
//   all 32 hash bits through the remainder (skipped for a zero modulus), then
//   holds out_ch.valid with the result until out_ch.ready. A new hash is popped
//   only after that result is taken.
// Stall: a stalled out_ch holds the result; the queue (QUEUE_DEPTH hashes)
//   then fills and in_ch.ready drops. Reset clears the hash, the queue and
//   the back, and restores the modulus; no clearing pass is needed.
`default_nettype none

module shift_xor_string_hash_mod #(
  parameter int QUEUE_DEPTH = shx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  shx_in_if.sink     in_ch,
  shx_out_if.source  out_ch,
  shx_cfg_if.sink    cfg
);
  import shx_pkg::*;

  logic [MOD_W-1:0]  modulus;
  q_wr_t             wr;
  q_stat_t           stat;
  logic              pop;
  logic [HASH_W-1:0] rd_data;

  // accept a modulus write on any cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg.valid) begin
      modulus <= cfg.data;
    end
  end

  shx_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .stat  (stat),
    .wr    (wr)
  );

  shx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .pop     (pop),
    .rd_data (rd_data),
    .stat    (stat)
  );

  shx_back u_back (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .rd_data (rd_data),
    .stat    (stat),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  // every key end must land in the queue
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.last_byte) |-> wr.valid)
    else $error("key end did not push a hash");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> !stat.full)
    else $error("push into full hash queue");

  // the back only pops a queue that holds something
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty hash queue");

  // a reduced hash stays below a nonzero modulus
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (modulus != '0)) |-> (out_ch.bucket_index < modulus))
    else $error("bucket index not below modulus");
`endif

endmodule

`default_nettype wire
